// ===== rtl/tri_rz_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tri_rz_pkg
// Shared constants for the edge-function rasterizer with z-buffer.
// ----------------------------------------------------------------------------
package tri_rz_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_DEPTH = 2'd0;
    localparam logic [1:0] REG_MAX_DEPTH = 2'd1;
    localparam logic [1:0] REG_WIDTH     = 2'd2;
    localparam logic [1:0] REG_HEIGHT    = 2'd3;

    // input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam int unsigned GREY_MAX = 255;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_EDGE  = 4'd3;
    localparam logic [3:0] ST_NUM   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_TEST  = 4'd6;
    localparam logic [3:0] ST_GMUL  = 4'd7;
    localparam logic [3:0] ST_GDIV  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_AREA  = 4'd10;

endpackage
`default_nettype wire

// ===== rtl/triangle_rasteriser_zbuffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_rasteriser_zbuffer
// Triangle scan with edge functions, barycentric depth and a z-buffer memory.
// ----------------------------------------------------------------------------
// Sequencing: a start transfer passes ST_AREA and ST_SETUP; a step on an idle scan
// is answered directly from ST_IDLE; an uncovered pixel passes ST_EDGE, ST_NUM and
// ST_EMIT; a covered pixel adds ST_DIV and ST_TEST, and when it passes the depth test
// and needs a grey division also ST_GMUL and ST_GDIV (one shared bit-serial divider).
// Throughput: one item at a time, busy high until its result strobe.
// Reset: synchronous; then a clearing pass writes MAX_WIDTH*MAX_HEIGHT
// depth entries (one a cycle) while busy stays high. Configuration is taken.
module triangle_rasteriser_zbuffer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire                         i_func,
    input  wire signed [COORD_BITS-1:0] i_vertex0_x,
    input  wire signed [COORD_BITS-1:0] i_vertex0_y,
    input  wire signed [DEPTH_BITS-1:0] i_vertex0_z,
    input  wire signed [COORD_BITS-1:0] i_vertex1_x,
    input  wire signed [COORD_BITS-1:0] i_vertex1_y,
    input  wire signed [DEPTH_BITS-1:0] i_vertex1_z,
    input  wire signed [COORD_BITS-1:0] i_vertex2_x,
    input  wire signed [COORD_BITS-1:0] i_vertex2_y,
    input  wire signed [DEPTH_BITS-1:0] i_vertex2_z,
    output logic                        o_strobe,
    output logic [7:0]                  o_pixel_x,
    output logic [7:0]                  o_pixel_y,
    output logic [7:0]                  o_grey_level,
    output logic                        o_pixel_written,
    output logic                        o_scan_done,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [3:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tri_rz_pkg::*;

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int AB    = XB + YB;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int DB    = COORD_BITS + 2;           // coordinate difference
    localparam int EB    = 2 * DB + 1;               // edge function
    localparam int NB    = EB + DEPTH_BITS + 2;      // depth numerator
    localparam int GB    = DEPTH_BITS + 10;          // grey numerator
    localparam int QB    = (NB > GB) ? NB : GB;      // divider width
    localparam int CB    = $clog2(QB + 1);

    // ---------------- configuration registers ----------------
    logic signed [15:0] r_min_lvl, r_max_lvl;
    logic [8:0]         r_scr_w, r_scr_h;
    logic               cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lvl <= '0;
            r_max_lvl <= '0;
            r_scr_w   <= 9'd256;
            r_scr_h   <= 9'd256;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MIN_DEPTH: r_min_lvl <= pwdata[15:0];
                REG_MAX_DEPTH: r_max_lvl <= pwdata[15:0];
                REG_WIDTH:     r_scr_w   <= pwdata[8:0];
                REG_HEIGHT:    r_scr_h   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MIN_DEPTH: prdata = {16'd0, r_min_lvl};
            REG_MAX_DEPTH: prdata = {16'd0, r_max_lvl};
            REG_WIDTH:     prdata = {23'd0, r_scr_w};
            REG_HEIGHT:    prdata = {23'd0, r_scr_h};
            default:       prdata = '0;
        endcase
    end

    // effective screen size, clamped to 1..MAX
    logic [12:0] eff_w, eff_h;
    always_comb begin
        eff_w = (r_scr_w == 9'd0) ? 13'd1 : {4'd0, r_scr_w};
        if (eff_w > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
        eff_h = (r_scr_h == 9'd0) ? 13'd1 : {4'd0, r_scr_h};
        if (eff_h > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
    end

    // ---------------- triangle state ----------------
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [DEPTH_BITS-1:0] r_z0, r_z1, r_z2;
    logic signed [EB-1:0]         r_area;
    logic [XB-1:0]                r_left, r_right, r_sx;
    logic [YB-1:0]                r_bot, r_top, r_sy;
    logic                         r_active;
    logic [3:0]                   r_state;
    logic [AB:0]                  r_clr;
    logic signed [EB-1:0]         r_e01, r_e12, r_e20;
    logic signed [NB-1:0]         r_num;
    logic signed [DEPTH_BITS-1:0] r_z;
    logic [AB-1:0]                r_addr;
    logic signed [GB-1:0]         r_gnum;
    logic                         r_wr;
    logic [7:0]                   r_grey;

    // ---------------- depth memory ----------------
    logic signed [DEPTH_BITS-1:0] mem [DEPTH];
    logic signed [DEPTH_BITS-1:0] r_rdata;
    logic                         mem_we;
    logic [AB-1:0]                mem_wa;
    logic signed [DEPTH_BITS-1:0] mem_wd;
    localparam logic signed [DEPTH_BITS-1:0] Z_LOW = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[r_addr];
    end

    // ---------------- bit-serial divider (shared) ----------------
    // unsigned restoring division, one quotient bit per cycle
    logic [QB-1:0] r_dq, r_dr, r_dd;
    logic [CB-1:0] r_dcnt;
    logic          r_dneg, r_dmod;
    logic [QB:0]   dtrial;
    assign dtrial = {r_dr, r_dq[QB-1]} - {1'b0, r_dd};

    // edge function of pixel (px,py) against edge a->b
    function automatic logic signed [EB-1:0] edge_f(
        input logic signed [DB-1:0] ax, input logic signed [DB-1:0] ay,
        input logic signed [DB-1:0] bx, input logic signed [DB-1:0] by,
        input logic signed [DB-1:0] px, input logic signed [DB-1:0] py);
        logic signed [EB-1:0] dbx, dpy, dby, dpx;
        dbx = EB'(bx) - EB'(ax);
        dpy = EB'(py) - EB'(ay);
        dby = EB'(by) - EB'(ay);
        dpx = EB'(px) - EB'(ax);
        return dbx * dpy - dby * dpx;
    endfunction

    logic signed [DB-1:0] px_s, py_s;
    assign px_s = DB'($signed({1'b0, r_sx}));
    assign py_s = DB'($signed({1'b0, r_sy}));

    // start-item box
    logic signed [COORD_BITS-1:0] mnx, mxx, mny, mxy;
    logic signed [DB-1:0]         cl, cr, cb, ct;
    logic                         box_ok;
    always_comb begin
        mnx = i_vertex0_x; mxx = i_vertex0_x;
        mny = i_vertex0_y; mxy = i_vertex0_y;
        if (i_vertex1_x < mnx) mnx = i_vertex1_x;
        if (i_vertex2_x < mnx) mnx = i_vertex2_x;
        if (i_vertex1_x > mxx) mxx = i_vertex1_x;
        if (i_vertex2_x > mxx) mxx = i_vertex2_x;
        if (i_vertex1_y < mny) mny = i_vertex1_y;
        if (i_vertex2_y < mny) mny = i_vertex2_y;
        if (i_vertex1_y > mxy) mxy = i_vertex1_y;
        if (i_vertex2_y > mxy) mxy = i_vertex2_y;
        cl = (mnx < 0) ? '0 : DB'(mnx);
        cb = (mny < 0) ? '0 : DB'(mny);
        cr = (DB'(mxx) > DB'($signed({1'b0, eff_w}) - 1)) ?
             DB'($signed({1'b0, eff_w}) - 1) : DB'(mxx);
        ct = (DB'(mxy) > DB'($signed({1'b0, eff_h}) - 1)) ?
             DB'($signed({1'b0, eff_h}) - 1) : DB'(mxy);
        box_ok = (cl <= cr) && (cb <= ct);
    end

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // scan advance
    logic          y_wrap, x_wrap, scan_last;
    assign y_wrap    = (r_sy >= r_top);
    assign x_wrap    = (r_sx >= r_right);
    assign scan_last = y_wrap && x_wrap;

    logic signed [NB-1:0] p12, p20, p01;
    logic covered;
    assign covered = r_area[EB-1] ? (r_e01 <= 0 && r_e12 <= 0 && r_e20 <= 0)
                                  : (r_e01 >= 0 && r_e12 >= 0 && r_e20 >= 0);
    assign p12 = NB'(r_e12) * NB'(r_z0);
    assign p20 = NB'(r_e20) * NB'(r_z1);
    assign p01 = NB'(r_e01) * NB'(r_z2);

    logic signed [17:0] range;
    assign range = 18'(r_max_lvl) - 18'(r_min_lvl);

    // floor of the signed quotient: round away from zero on a negative remainder
    logic signed [QB:0] quot_s;
    assign quot_s = r_dneg ? -$signed({1'b0, r_dq}) - $signed({{QB{1'b0}}, (r_dr != '0)})
                           : $signed({1'b0, r_dq});
    logic [AB+12:0] addr_full;
    assign addr_full = (AB+13)'(r_sx) + (AB+13)'(r_sy) * (AB+13)'(eff_w);

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        mem_we   <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_active <= 1'b0;
            r_sx <= '0; r_sy <= '0;
            r_left <= '0; r_right <= '0; r_bot <= '0; r_top <= '0;
            r_area <= '0;
            r_x0 <= '0; r_y0 <= '0; r_z0 <= '0;
            r_x1 <= '0; r_y1 <= '0; r_z1 <= '0;
            r_x2 <= '0; r_y2 <= '0; r_z2 <= '0;
        end else begin
            unique case (r_state) inside
                ST_CLEAR: begin
                    mem_we <= 1'b1;
                    mem_wa <= r_clr[AB-1:0];
                    mem_wd <= Z_LOW;
                    r_clr  <= r_clr + 1'b1;
                    if (r_clr == (AB+1)'(DEPTH - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        if (i_func == FUNC_START) begin
                            r_x0 <= i_vertex0_x; r_y0 <= i_vertex0_y; r_z0 <= i_vertex0_z;
                            r_x1 <= i_vertex1_x; r_y1 <= i_vertex1_y; r_z1 <= i_vertex1_z;
                            r_x2 <= i_vertex2_x; r_y2 <= i_vertex2_y; r_z2 <= i_vertex2_z;
                            r_left <= XB'(cl); r_right <= XB'(cr);
                            r_bot  <= YB'(cb); r_top   <= YB'(ct);
                            r_active <= box_ok;
                            r_state  <= ST_AREA;
                        end else if (!r_active) begin
                            o_strobe <= 1'b1;
                            o_pixel_x <= '0; o_pixel_y <= '0; o_grey_level <= '0;
                            o_pixel_written <= 1'b0; o_scan_done <= 1'b1;
                        end else begin
                            r_state <= ST_EDGE;
                        end
                    end
                end
                ST_AREA: begin
                    r_area <= edge_f(DB'(r_x0), DB'(r_y0), DB'(r_x1), DB'(r_y1),
                                     DB'(r_x2), DB'(r_y2));
                    r_state <= ST_SETUP;
                end
                ST_SETUP: begin
                    if (r_area == '0 || !r_active) begin
                        r_active <= 1'b0;
                        r_left <= '0; r_right <= '0; r_bot <= '0; r_top <= '0;
                        r_sx <= '0; r_sy <= '0;
                    end else begin
                        r_sx <= r_left; r_sy <= r_bot;
                    end
                    o_strobe <= 1'b1;
                    o_pixel_x <= '0; o_pixel_y <= '0; o_grey_level <= '0;
                    o_pixel_written <= 1'b0;
                    o_scan_done <= (r_area == '0 || !r_active);
                    r_state <= ST_IDLE;
                end
                ST_EDGE: begin
                    r_e01 <= edge_f(DB'(r_x0), DB'(r_y0), DB'(r_x1), DB'(r_y1), px_s, py_s);
                    r_e12 <= edge_f(DB'(r_x1), DB'(r_y1), DB'(r_x2), DB'(r_y2), px_s, py_s);
                    r_e20 <= edge_f(DB'(r_x2), DB'(r_y2), DB'(r_x0), DB'(r_y0), px_s, py_s);
                    r_addr <= AB'(addr_full);
                    r_wr   <= 1'b0;
                    r_grey <= '0;
                    r_state <= ST_NUM;
                end
                ST_NUM: begin
                    if (!covered) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_num   <= p12 + p20 + p01;
                        r_state <= ST_DIV;
                        r_dmod  <= 1'b0;
                        r_dcnt  <= '0;
                    end
                end
                ST_DIV, ST_GDIV: begin
                    if (r_dcnt == '0 && !r_dmod && r_state == ST_DIV) begin
                        r_dq   <= QB'(r_num[NB-1] ? -r_num : r_num);
                        r_dd   <= QB'(r_area[EB-1] ? -r_area : r_area);
                        r_dneg <= r_num[NB-1] ^ r_area[EB-1];
                        r_dr   <= '0;
                        r_dmod <= 1'b1;
                    end else if (r_dcnt == CB'(QB)) begin
                        r_dcnt <= '0;
                        r_dmod <= 1'b0;
                        if (r_state == ST_DIV) begin
                            if (quot_s < $signed((QB+1)'(Z_LOW))) r_z <= Z_LOW;
                            else if (quot_s > $signed((QB+1)'(~Z_LOW))) r_z <= ~Z_LOW;
                            else r_z <= DEPTH_BITS'(quot_s);
                            r_state <= ST_TEST;
                        end else begin
                            // truncating division: quotient sign follows numerator
                            if (r_dneg) r_grey <= '0;
                            else if (r_dq > QB'(GREY_MAX)) r_grey <= 8'(GREY_MAX);
                            else r_grey <= r_dq[7:0];
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                        if (!dtrial[QB]) begin
                            r_dr <= dtrial[QB-1:0];
                            r_dq <= {r_dq[QB-2:0], 1'b1};
                        end else begin
                            r_dr <= {r_dr[QB-2:0], r_dq[QB-1]};
                            r_dq <= {r_dq[QB-2:0], 1'b0};
                        end
                    end
                end
                ST_TEST: begin
                    if (r_z > r_rdata) begin
                        mem_we <= 1'b1;
                        mem_wa <= r_addr;
                        mem_wd <= r_z;
                        r_wr   <= 1'b1;
                        if (range > 0) begin
                            r_gnum  <= GB'(255) * (GB'(r_z) - GB'(r_min_lvl));
                            r_state <= ST_GMUL;
                        end else begin
                            r_grey  <= 8'(GREY_MAX);
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_GMUL: begin
                    r_dq   <= QB'(r_gnum[GB-1] ? -r_gnum : r_gnum);
                    r_dd   <= QB'(range);
                    r_dneg <= r_gnum[GB-1] && (r_gnum != '0);
                    r_dr   <= '0;
                    r_dcnt <= '0;
                    r_dmod <= 1'b1;
                    r_state <= ST_GDIV;
                end
                ST_EMIT: begin
                    o_strobe <= 1'b1;
                    o_pixel_x <= 8'(r_sx);
                    o_pixel_y <= 8'(r_sy);
                    o_grey_level <= r_grey;
                    o_pixel_written <= r_wr;
                    o_scan_done <= scan_last;
                    if (scan_last) begin
                        r_active <= 1'b0; r_sx <= '0; r_sy <= '0;
                    end else if (y_wrap) begin
                        r_sy <= r_bot; r_sx <= r_sx + 1'b1;
                    end else begin
                        r_sy <= r_sy + 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_busy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> busy) else $error("accept during clear");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == ST_IDLE)) else $error("strobe while busy");
    a_write_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_pixel_written) |-> (o_grey_level == 8'd0))
        else $error("grey on unwritten pixel");
    a_done_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_scan_done) |-> !r_active) else $error("done but active");

endmodule
`default_nettype wire

// ===== test/tb_triangle_rasteriser_zbuffer.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_rasteriser_zbuffer
// Self-checking bench for the rasterizer: drives triangle starts and pixel
// steps through the start/busy handshake, writes registers over APB between
// phases, and compares every result strobe against a scan/depth predictor.
// ----------------------------------------------------------------------------
module tb_triangle_rasteriser_zbuffer;
    timeunit 1ns;
    timeprecision 1ps;
    import tri_rz_pkg::*;

    typedef struct {
        logic                    func;
        logic signed [11:0]      vx [3];
        logic signed [11:0]      vy [3];
        logic signed [15:0]      vz [3];
    } tri_cmd_t;

    typedef struct packed {
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] grey;
        logic       written;
        logic       done;
    } pixel_res_t;

    // scan and depth predictor with its queue of pending pixel results
    class raster_scoreboard;
        shortint     zbuf [65536];
        longint      vx [3], vy [3], vz [3];
        longint      area, bl, br, bb, bt, sx, sy;
        bit          active;
        logic [15:0] lo_raw, hi_raw;
        logic [8:0]  w_raw, h_raw;
        pixel_res_t  pending [$];
        int          errors, n_start, n_step, n_written;

        function new();
            foreach (zbuf[i]) zbuf[i] = shortint'(-32768);
            foreach (vx[k]) begin
                vx[k] = 0; vy[k] = 0; vz[k] = 0;
            end
            area = 0; bl = 0; br = 0; bb = 0; bt = 0; sx = 0; sy = 0;
            active = 0;
            lo_raw = 16'd0; hi_raw = 16'd0; w_raw = 9'd256; h_raw = 9'd256;
            errors = 0; n_start = 0; n_step = 0; n_written = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_MIN_DEPTH: lo_raw = val[15:0];
                REG_MAX_DEPTH: hi_raw = val[15:0];
                REG_WIDTH:     w_raw  = val[8:0];
                default:       h_raw  = val[8:0];
            endcase
        endfunction

        function longint clamp_dim(logic [8:0] raw);
            longint v;
            v = longint'(raw);
            if (v < 1) v = 1;
            if (v > 256) v = 256;
            return v;
        endfunction

        function longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                 longint px, longint py);
            return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
        endfunction

        // one accepted item -> one expected result
        function void note(tri_cmd_t c);
            pixel_res_t r;
            longint     w, h, e01, e12, e20, num, z, q, lo, hi, g, addr;
            bit         cov;
            r = '0;
            w = clamp_dim(w_raw);
            h = clamp_dim(h_raw);
            if (c.func == FUNC_START) begin
                n_start++;
                foreach (vx[k]) begin
                    vx[k] = longint'(c.vx[k]);
                    vy[k] = longint'(c.vy[k]);
                    vz[k] = longint'(c.vz[k]);
                end
                area = edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
                bl = vx[0]; br = vx[0]; bb = vy[0]; bt = vy[0];
                for (int k = 1; k < 3; k++) begin
                    if (vx[k] < bl) bl = vx[k];
                    if (vx[k] > br) br = vx[k];
                    if (vy[k] < bb) bb = vy[k];
                    if (vy[k] > bt) bt = vy[k];
                end
                if (bl < 0) bl = 0;
                if (bb < 0) bb = 0;
                if (br > w - 1) br = w - 1;
                if (bt > h - 1) bt = h - 1;
                active = (area != 0) && (bl <= br) && (bb <= bt);
                if (active) begin
                    sx = bl; sy = bb;
                end else begin
                    bl = 0; br = 0; bb = 0; bt = 0; sx = 0; sy = 0;
                end
                r.done = !active;
            end else if (!active) begin
                r.done = 1;
            end else begin
                n_step++;
                e01 = edge_fn(vx[0], vy[0], vx[1], vy[1], sx, sy);
                e12 = edge_fn(vx[1], vy[1], vx[2], vy[2], sx, sy);
                e20 = edge_fn(vx[2], vy[2], vx[0], vy[0], sx, sy);
                cov = (area > 0) ? (e01 >= 0 && e12 >= 0 && e20 >= 0)
                                 : (e01 <= 0 && e12 <= 0 && e20 <= 0);
                r.px = sx[7:0];
                r.py = sy[7:0];
                if (cov) begin
                    num = e12 * vz[0] + e20 * vz[1] + e01 * vz[2];
                    // floor division
                    q = num / area;
                    if ((num % area != 0) && ((num < 0) != (area < 0))) q--;
                    z = q;
                    if (z < -32768) z = -32768;
                    if (z > 32767) z = 32767;
                    addr = sx + sy * w;
                    if (addr < 65536 && z > zbuf[addr]) begin
                        zbuf[addr] = shortint'(z);
                        lo = longint'($signed(lo_raw));
                        hi = longint'($signed(hi_raw));
                        g = 255;
                        if (hi > lo) begin
                            g = (255 * (z - lo)) / (hi - lo);
                            if (g < 0) g = 0;
                            if (g > 255) g = 255;
                        end
                        r.grey = g[7:0];
                        r.written = 1;
                        n_written++;
                    end
                end
                sy++;
                if (sy > bt) begin
                    sy = bb;
                    sx++;
                    if (sx > br) begin
                        active = 0; sx = 0; sy = 0;
                    end
                end
                r.done = !active;
            end
            pending.push_back(r);
        endfunction

        function void check(pixel_res_t got);
            pixel_res_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result strobe, got %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.px != exp_r.px)
                $display("%0t: pixel_x exp %0d got %0d", $time, exp_r.px, got.px);
            if (got.py != exp_r.py)
                $display("%0t: pixel_y exp %0d got %0d", $time, exp_r.py, got.py);
            if (got.grey != exp_r.grey)
                $display("%0t: grey_level exp %0d got %0d", $time, exp_r.grey, got.grey);
            if (got.written != exp_r.written)
                $display("%0t: pixel_written exp %0d got %0d", $time,
                         exp_r.written, got.written);
            if (got.done != exp_r.done)
                $display("%0t: scan_done exp %0d got %0d", $time, exp_r.done, got.done);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic        i_clk, i_rst_n, start, busy;
    logic        o_strobe, o_pixel_written, o_scan_done;
    logic [7:0]  o_pixel_x, o_pixel_y, o_grey_level;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    tri_cmd_t    cur;
    int          n_items;
    int          burst_left;

    raster_scoreboard sb;

    triangle_rasteriser_zbuffer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(cur.func),
        .i_vertex0_x(cur.vx[0]), .i_vertex0_y(cur.vy[0]), .i_vertex0_z(cur.vz[0]),
        .i_vertex1_x(cur.vx[1]), .i_vertex1_y(cur.vy[1]), .i_vertex1_z(cur.vz[1]),
        .i_vertex2_x(cur.vx[2]), .i_vertex2_y(cur.vy[2]), .i_vertex2_z(cur.vz[2]),
        .o_strobe(o_strobe), .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y),
        .o_grey_level(o_grey_level), .o_pixel_written(o_pixel_written),
        .o_scan_done(o_scan_done),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // input transfers and result strobes, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note(cur);
        if (i_rst_n && o_strobe)
            sb.check({o_pixel_x, o_pixel_y, o_grey_level, o_pixel_written, o_scan_done});
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // drop start, then wait until nothing is in flight
    task automatic wait_idle();
        @(negedge i_clk);
        start = 0;
        burst_left = 0;
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // send one item; start stays high when another follows without a gap
    task automatic send(tri_cmd_t c, bit hold);
        @(negedge i_clk);
        cur = c;
        start = 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // let the monitor note the transfer before the predictor is read
        #1;
        n_items++;
        if (!hold) begin
            @(negedge i_clk);
            start = 0;
        end
    endtask

    // burst/gap pacing around send
    task automatic push(tri_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        send(c, burst_left != 0);
    endtask

    function automatic tri_cmd_t mk_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                        int x2, int y2, int z2);
        tri_cmd_t c;
        c.func = FUNC_START;
        c.vx[0] = 12'(x0); c.vy[0] = 12'(y0); c.vz[0] = 16'(z0);
        c.vx[1] = 12'(x1); c.vy[1] = 12'(y1); c.vz[1] = 16'(z1);
        c.vx[2] = 12'(x2); c.vy[2] = 12'(y2); c.vz[2] = 16'(z2);
        return c;
    endfunction

    function automatic tri_cmd_t mk_step();
        tri_cmd_t c;
        c.func = FUNC_STEP;
        foreach (c.vx[k]) begin
            c.vx[k] = 12'($urandom); c.vy[k] = 12'($urandom); c.vz[k] = 16'($urandom);
        end
        return c;
    endfunction

    // small triangle near the origin with random depths
    function automatic tri_cmd_t rand_small();
        tri_cmd_t c;
        int bx, by;
        c.func = FUNC_START;
        bx = $urandom_range(0, 24) - 4;
        by = $urandom_range(0, 24) - 4;
        foreach (c.vx[k]) begin
            c.vx[k] = 12'(bx + $urandom_range(0, 6));
            c.vy[k] = 12'(by + $urandom_range(0, 6));
            c.vz[k] = 16'($urandom);
        end
        return c;
    endfunction

    function automatic tri_cmd_t rand_any();
        tri_cmd_t c;
        c = mk_step();
        c.func = FUNC_START;
        return c;
    endfunction

    task automatic scan_all();
        int guard;
        guard = 0;
        while (sb.active && guard < 60) begin
            push(mk_step());
            guard++;
        end
    endtask

    task automatic set_levels(int lo, int hi, int w, int h);
        wait_idle();
        reg_write(REG_MIN_DEPTH, lo);
        reg_write(REG_MAX_DEPTH, hi);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    initial begin
        sb = new();
        n_items = 0;
        burst_left = 0;
        start = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        cur = mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // clearing pass after reset
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed: idle step, degenerate, empty box, extremes, ties
        send(mk_step(), 0);
        send(mk_tri(1, 1, 0, 3, 3, 0, 5, 5, 0), 0);
        send(mk_tri(-2048, -2048, 0, -5, -2048, 0, -2048, -1, 0), 0);
        send(mk_tri(300, 10, 0, 400, 10, 0, 300, 40, 0), 0);
        send(mk_tri(0, 0, -32768, 3, 0, -32768, 0, 3, -32768), 0);
        scan_all();
        set_levels(-256, 256, 256, 256);
        send(mk_tri(0, 0, 32767, 0, 3, -32768, 3, 0, 100), 0);
        scan_all();
        send(mk_tri(0, 0, 500, 3, 0, 500, 0, 3, 500), 0);
        scan_all();
        send(mk_step(), 0);
        send(mk_tri(-2048, 2047, 32767, 2047, 2047, -32768, 0, -2048, 0), 0);
        repeat (4) send(mk_step(), 0);
        set_levels(32767, -32768, 0, 511);
        send(mk_tri(0, 0, 256, 0, 5, 256, 5, 0, 256), 0);
        scan_all();
        set_levels(-32768, 32767, 4, 300);
        send(mk_tri(1, 1, 1000, 8, 2, 2000, 2, 8, -3000), 0);
        repeat (5) send(mk_step(), 0);
        // size change while a scan is active
        set_levels(-32768, 32767, 1, 3);
        scan_all();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: set_levels($urandom, $urandom, $urandom_range(1, 32),
                              $urandom_range(1, 32));
                1: set_levels(-512, 512, 256, 256);
                2: set_levels($urandom, $urandom, $urandom_range(0, 511),
                              $urandom_range(0, 511));
                default: set_levels(0, 0, 16, 16);
            endcase
            while (n_items < 40 + (ph + 1) * 100) begin
                case ($urandom_range(0, 9))
                    0: push(rand_any());
                    1: push(mk_step());
                    default: begin
                        push(rand_small());
                        if ($urandom_range(0, 5) == 0) begin
                            repeat ($urandom_range(1, 4)) push(mk_step());
                        end else begin
                            scan_all();
                            if ($urandom_range(0, 3) == 0) push(mk_step());
                        end
                    end
                endcase
            end
            burst_left = 0;
            @(negedge i_clk);
            start = 0;
        end

        wait_idle();
        repeat (120) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        $display("Covered %0d items: %0d triangle starts, %0d scanned pixels, %0d written.",
                 n_items, sb.n_start, sb.n_step, sb.n_written);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hard stop
    initial begin
        #8ms;
        $display("FAIL");
        $finish;
    end

endmodule
